// ===== sv/frame_sequence_reorder_buffer_defines.svh =====
// Assertion macros for the frame sequence reorder buffer.
// No dependencies.
`ifndef FRAME_SEQUENCE_REORDER_BUFFER_DEFINES_SVH
`define FRAME_SEQUENCE_REORDER_BUFFER_DEFINES_SVH
`define FSRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FSRB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

// ===== sv/fsrb_pkg.sv =====
// Package for the frame sequence reorder buffer: sizes, codes and item types.
// No dependencies.
package fsrb_pkg;
  localparam int unsigned WinSlots = 16;
  localparam int unsigned WinW = $clog2(WinSlots);
  localparam int unsigned HistDepth = 32;
  localparam int unsigned HistW = $clog2(HistDepth);

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_DROP = 2'd1;
  localparam logic [1:0] KIND_SNAP = 2'd2;
  localparam logic [1:0] KIND_COUNT = 2'd3;

  localparam logic [1:0] RES_REL = 2'd0;
  localparam logic [1:0] RES_SNAP = 2'd1;
  localparam logic [1:0] RES_COUNT = 2'd2;
  localparam logic [1:0] RES_REJECT = 2'd3;

  localparam logic CFG_REORDER = 1'b0;
  localparam logic CFG_HISTORY = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [31:0] frame_tag;
    logic [5:0]  snapshot_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] out_seq;
    logic [31:0] out_tag;
    logic        gap_skipped;
    logic [5:0]  history_fill;
    logic        last;
  } out_item_t;
endpackage

// ===== sv/frame_sequence_reorder_buffer.sv =====
// Frame sequence reorder buffer top level: sequencer, slot window and history ring.
// Depends on fsrb_pkg and frame_sequence_reorder_buffer_defines.svh.
//
//  channel  | direction | handshake
//  in       | input     | in_valid_i / in_stall_o
//  out      | output    | out_valid_o / out_stall_i
//  cfg      | input     | cfg_valid_i / cfg_ready_o, index and data
//
// Completion or drop: accept, walk releasing or passing slots, final check, hand the
// last release out; a skip adds k probe and k clear steps (k <= WinSlots-1).
// Snapshot: accept, then one result per entry. Count or reject: result registered at
// accept. The walk and snapshot pause while the output register is full and stalled;
// input and cfg wait until idle with no result held. Reset clears all marks at once.
`include "frame_sequence_reorder_buffer_defines.svh"
module frame_sequence_reorder_buffer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fsrb_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fsrb_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [5:0]         cfg_data_i
);
  import fsrb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_SNAP = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] st_q, st_d;
  logic [31:0] exp_q, exp_d;
  logic [WinSlots-1:0] has_q, has_d, drp_q, drp_d;
  logic [31:0] tag_mem [WinSlots];
  logic [4:0] pend_q, pend_d;
  logic [31:0] hs_mem [HistDepth];
  logic [31:0] ht_mem [HistDepth];
  logic [HistW-1:0] head_q, head_d;
  logic [5:0] tot_q, tot_d;
  logic skip_q, skip_d;
  logic [4:0] rlim_q;
  logic [5:0] hlim_q;
  logic [WinW:0] k_q, k_d;
  logic [5:0] cnt_q, cnt_d;
  logic [HistW-1:0] rd_q, rd_d;
  logic ov_q, ov_d;
  out_item_t o_q, o_d;
  out_item_t pr_q, pr_d;
  logic prv_q, prv_d;

  logic [WinW-1:0] s;
  logic can_go, tag_we, h_we;
  logic [WinW-1:0] tag_wa;
  logic [31:0] room, diff;
  logic [5:0] cap, ntot;
  logic [WinW-1:0] ks;

  assign can_go = !ov_q || !out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE) || ov_q;
  assign cfg_ready_o = (st_q == ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_item_o = o_q;
  assign s = exp_q[WinW-1:0];
  assign diff = in_item_i.seq - exp_q;
  assign room = 32'hFFFF_FFFF - exp_q;
  assign cap = (hlim_q > 6'(HistDepth)) ? 6'(HistDepth) : hlim_q;
  assign ntot = (tot_q + 6'd1 > cap) ? cap : tot_q + 6'd1;
  assign ks = WinW'(exp_q + 32'(k_q));

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= in_item_i.frame_tag;
    if (h_we) begin
      hs_mem[head_q] <= exp_q;
      ht_mem[head_q] <= tag_mem[s];
    end
  end

  always_comb begin
    st_d = st_q; exp_d = exp_q; has_d = has_q; drp_d = drp_q; pend_d = pend_q;
    head_d = head_q; tot_d = tot_q; skip_d = skip_q; k_d = k_q; cnt_d = cnt_q;
    rd_d = rd_q; ov_d = ov_q && out_stall_i; o_d = o_q; pr_d = pr_q; prv_d = prv_q;
    tag_we = 1'b0; tag_wa = in_item_i.seq[WinW-1:0]; h_we = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          case (in_item_i.kind)
            KIND_DONE, KIND_DROP: begin
              if (in_item_i.seq >= exp_q) begin
                if (diff >= 32'(WinSlots)) begin
                  ov_d = 1'b1;
                  o_d = '{RES_REJECT, in_item_i.seq,
                          (in_item_i.kind == KIND_DONE) ? in_item_i.frame_tag : 32'd0,
                          1'b0, tot_q, 1'b1};
                end else begin
                  if (in_item_i.kind == KIND_DONE) begin
                    tag_we = 1'b1;
                    if (!has_q[tag_wa]) begin
                      has_d[tag_wa] = 1'b1;
                      pend_d = pend_q + 5'd1;
                    end
                  end else begin
                    drp_d[tag_wa] = 1'b1;
                  end
                  st_d = ST_WALK;
                end
              end
            end
            KIND_SNAP: begin
              cnt_d = (in_item_i.snapshot_count < tot_q) ? in_item_i.snapshot_count : tot_q;
              rd_d = head_q - HistW'(cnt_d);
              if (cnt_d != 6'd0) st_d = ST_SNAP;
            end
            default: begin
              ov_d = 1'b1;
              o_d = '{RES_COUNT, 32'd0, 32'd0, 1'b0, tot_q, 1'b1};
            end
          endcase
        end
      end
      ST_WALK: begin
        if (can_go) begin
          if (has_q[s]) begin
            has_d[s] = 1'b0; drp_d[s] = 1'b0;
            if (pend_q != 5'd0) pend_d = pend_q - 5'd1;
            h_we = 1'b1;
            head_d = head_q + HistW'(1);
            tot_d = ntot;
            // previous release leaves now; this one waits until we know if it is last
            if (prv_q) begin
              ov_d = 1'b1;
              o_d = pr_q;
            end
            pr_d = '{RES_REL, exp_q, tag_mem[s], skip_q, ntot, 1'b0};
            prv_d = 1'b1;
            skip_d = 1'b0;
            exp_d = exp_q + 32'd1;
          end else if (drp_q[s]) begin
            drp_d[s] = 1'b0;
            exp_d = exp_q + 32'd1;
          end else if (pend_q > rlim_q) begin
            k_d = (WinW+1)'(1);
            st_d = ST_SCAN;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (k_q >= (WinW+1)'(WinSlots) || 32'(k_q) > room) begin
          st_d = ST_DONE;
        end else if (has_q[ks]) begin
          k_d = '0;
          cnt_d = 6'(k_q);
          st_d = ST_CLR;
        end else begin
          k_d = k_q + (WinW+1)'(1);
        end
      end
      ST_CLR: begin
        drp_d[ks] = 1'b0;
        if (32'(k_q) + 32'd1 == 32'(cnt_q)) begin
          exp_d = exp_q + 32'(cnt_q);
          skip_d = 1'b1;
          st_d = ST_WALK;
        end else begin
          k_d = k_q + (WinW+1)'(1);
        end
      end
      ST_SNAP: begin
        if (can_go) begin
          ov_d = 1'b1;
          o_d = '{RES_SNAP, hs_mem[rd_q], ht_mem[rd_q], 1'b0, tot_q, cnt_q == 6'd1};
          rd_d = rd_q + HistW'(1);
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) st_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!prv_q) begin
          st_d = ST_IDLE;
        end else if (can_go) begin
          ov_d = 1'b1;
          o_d = pr_q;
          o_d.last = 1'b1;
          prv_d = 1'b0;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; exp_q <= '0; has_q <= '0; drp_q <= '0; pend_q <= '0;
      head_q <= '0; tot_q <= '0; skip_q <= 1'b0; rlim_q <= 5'd8; hlim_q <= 6'd32;
      k_q <= '0; cnt_q <= '0; rd_q <= '0; ov_q <= 1'b0; prv_q <= 1'b0;
    end else begin
      st_q <= st_d; exp_q <= exp_d; has_q <= has_d; drp_q <= drp_d; pend_q <= pend_d;
      head_q <= head_d; tot_q <= tot_d; skip_q <= skip_d;
      k_q <= k_d; cnt_q <= cnt_d; rd_q <= rd_d; ov_q <= ov_d; prv_q <= prv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_REORDER) rlim_q <= cfg_data_i[4:0];
        else hlim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    o_q <= o_d;
    pr_q <= pr_d;
  end

  `FSRB_ASSERT(a_busy_stall, (st_q != ST_IDLE) |-> in_stall_o, "busy but not stalling")
  `FSRB_ASSERT(a_tot_cap, tot_q <= 6'(HistDepth), "history fill beyond depth")
  `FSRB_ASSERT(a_out_hold, (ov_q && out_stall_i) |=> ov_q, "stalled result lost")
  `FSRB_ASSERT(a_out_stable, (ov_q && out_stall_i) |=> $stable(o_q), "stalled result changed")
  `FSRB_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")
endmodule
